// ===== rtl/eps_pkg.sv =====
package eps_pkg;

   localparam int BP_OFFS         = 0;
   localparam int BIN_PREFIX_STEP = 10;
   localparam int BP_COUNT        = 9;
   localparam int SI_OFFS         = 8;
   localparam int SI_PREFIX_STEP  = 3;
   localparam int SI_COUNT        = 17;

   localparam logic [3:0]  BASE_BIN   = 4'd2;
   localparam logic [3:0]  BASE_DEC   = 4'd10;
   localparam logic [3:0]  BASE_RESET = 4'd10;
   localparam logic [3:0]  PREC_RESET = 4'd2;

   localparam logic [1:0]  ERR_NONE      = 2'd0;
   localparam logic [1:0]  ERR_PRECISION = 2'd1;
   localparam logic [1:0]  ERR_BASE      = 2'd2;
   localparam logic [1:0]  ERR_RANGE     = 2'd3;

   localparam logic        REG_BASE = 1'b0;
   localparam logic        REG_PREC = 1'b1;

   localparam logic [31:0] ROUND_BIAS  = 32'd5;
   localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;
   localparam logic [4:0]  IP_QMSB     = 5'd10;
   localparam logic [4:0]  FP_QMSB     = 5'd29;
   localparam logic [10:0] WRAP_DEC    = 11'd1000;
   localparam logic [10:0] WRAP_BIN    = 11'd1024;

   typedef struct packed {
      logic signed [31:0] mantissa;
      logic signed [7:0]  exponent;
   } req_type;

   typedef struct packed {
      logic        negative;
      logic [9:0]  int_part;
      logic [26:0] frac_part;
      logic [3:0]  frac_digits;
      logic [4:0]  prefix_index;
      logic [1:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic [3:0] number_base;
      logic [3:0] precision;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
      logic [4:0]  qmsb;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   function automatic logic [31:0] pow10(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd0: r = 32'd1;
         4'd1: r = 32'd10;
         4'd2: r = 32'd100;
         4'd3: r = 32'd1000;
         4'd4: r = 32'd10000;
         4'd5: r = 32'd100000;
         4'd6: r = 32'd1000000;
         4'd7: r = 32'd10000000;
         4'd8: r = 32'd100000000;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic [35:0] times_base(input logic [35:0] x, input logic base2);
      return base2 ? {x[34:0], 1'b0} : ({x[32:0], 3'b000} + {x[34:0], 1'b0});
   endfunction

endpackage

// ===== rtl/engineering_prefix_scaler_top.sv =====
// Engineering-notation prefix scaler.
// Input channel req_*: one transfer carries a mantissa and a base exponent.
// Result channel rsp_*: one transfer per input, with sign, integer part,
// rounded fraction, fraction digit count, prefix table index and error code.
// Configuration port csr_*: number_base at 0x0, precision at 0x4; write only
// while no item is in flight.
// Each item passes the serial log loop (one base power per cycle), the
// exponent floor-divide loop (one prefix step per cycle), the base scaling
// loop, two passes of the shared shift-subtract divider, and the
// trailing-zero strip (a multiply state and a check state per digit).
// Errors in precision or base go from idle straight to the finish state.
// One item is worked at a time; req_stall is high while it is in work.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled result holds until taken, stalling the sequencer
// at its last step.
// Reset clears the channels and loads number_base 10 and precision 2.
module engineering_prefix_scaler_top #(
   parameter int MANTISSA_BITS = 32,
   parameter int MAX_PRECISION = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eps_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eps_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   eps_pkg::cfg_type      cfg;
   eps_pkg::div_req_type  div_req;
   eps_pkg::div_rsp_type  div_rsp;
   eps_pkg::rsp_type      res_data;
   eps_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  busy, res_valid, res_ready, req_fire;

   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   eps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   eps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   eps_seq #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .MAX_PRECISION (MAX_PRECISION)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .busy      (busy),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/eps_csr.sv =====
module eps_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output eps_pkg::cfg_type  cfg
);

   logic [3:0] base_ff, base_in;
   logic [3:0] prec_ff, prec_in;
   logic       wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      base_in = base_ff;
      prec_in = prec_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            eps_pkg::REG_BASE: base_in = csr_pwdata[3:0];
            eps_pkg::REG_PREC: prec_in = csr_pwdata[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= eps_pkg::BASE_RESET;
         prec_ff <= eps_pkg::PREC_RESET;
      end else begin
         base_ff <= base_in;
         prec_ff <= prec_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         eps_pkg::REG_BASE: csr_prdata = {28'd0, base_ff};
         eps_pkg::REG_PREC: csr_prdata = {28'd0, prec_ff};
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg.number_base = base_ff;
   assign cfg.precision   = prec_ff;

endmodule

// ===== rtl/eps_div.sv =====
module eps_div (
   input  logic                  clock,
   input  logic                  reset,
   input  eps_pkg::div_req_type  div_req,
   output eps_pkg::div_rsp_type  div_rsp
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] dsh_ff, dsh_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         acc_in  = div_req.dividend;
         dsh_in  = {32'd0, div_req.divisor} << div_req.qmsb;
         quo_in  = 32'd0;
         cnt_in  = div_req.qmsb;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (acc_ff >= dsh_ff) begin
            acc_in = acc_ff - dsh_ff;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            quo_in = {quo_ff[30:0], 1'b0};
         end
         dsh_in = {1'b0, dsh_ff[63:1]};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = acc_ff[31:0];

endmodule

// ===== rtl/eps_seq.sv =====
module eps_seq #(
   parameter int MANTISSA_BITS = 32,
   parameter int MAX_PRECISION = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  eps_pkg::cfg_type      cfg,
   input  logic                  req_fire,
   input  eps_pkg::req_type      req_data,
   output logic                  busy,
   input  logic                  res_ready,
   output logic                  res_valid,
   output eps_pkg::rsp_type      res_data,
   output eps_pkg::div_req_type  div_req,
   input  eps_pkg::div_rsp_type  div_rsp
);

   localparam logic [31:0] MMASK = 32'hFFFF_FFFF >> (32 - MANTISSA_BITS);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_LOG       = 12'b0000_0000_0010,
      ST_FDIV      = 12'b0000_0000_0100,
      ST_SCALE     = 12'b0000_0000_1000,
      ST_IPDIV     = 12'b0000_0001_0000,
      ST_FMUL      = 12'b0000_0010_0000,
      ST_FPDIV     = 12'b0000_0100_0000,
      ST_ROUND_MUL = 12'b0000_1000_0000,
      ST_ROUND_CHK = 12'b0001_0000_0000,
      ST_STRIP_MUL = 12'b0010_0000_0000,
      ST_STRIP_CHK = 12'b0100_0000_0000,
      ST_FINISH    = 12'b1000_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [7:0]  ys_ff, ys_in;
   logic        base2_ff, base2_in;
   logic [1:0]  err_ff, err_in;
   logic [35:0] pw_ff, pw_in;
   logic [5:0]  lg_ff, lg_in;
   logic [8:0]  r_ff, r_in;
   logic [7:0]  q_ff, q_in;
   logic        dneg_ff, dneg_in;
   logic [5:0]  scnt_ff, scnt_in;
   logic [31:0] scaled_ff, scaled_in;
   logic [31:0] dv_ff, dv_in;
   logic [9:0]  ip_ff, ip_in;
   logic [63:0] n_ff, n_in;
   logic [4:0]  ncnt_ff, ncnt_in;
   logic [31:0] fp_ff, fp_in;
   logic [63:0] prod_ff, prod_in;
   logic [3:0]  digits_ff, digits_in;
   logic        carry_ff, carry_in;

   logic [31:0] raw;
   logic [8:0]  step;
   logic [6:0]  d_w;
   logic [31:0] q10;
   logic [10:0] ip_inc;
   logic [8:0]  idx_w;
   logic        out_range;
   logic [1:0]  err_final;

   assign raw     = req_data.mantissa & MMASK;
   assign step    = base2_ff ? 9'(eps_pkg::BIN_PREFIX_STEP) : 9'(eps_pkg::SI_PREFIX_STEP);
   assign d_w     = {1'b0, lg_ff} - r_ff[6:0];
   assign q10     = {3'd0, prod_ff[63:eps_pkg::DIV10_SHIFT]};
   assign ip_inc  = {1'b0, ip_ff} + 11'd1;
   assign idx_w   = {q_ff[7], q_ff}
                  + (base2_ff ? 9'(eps_pkg::BP_OFFS) : 9'(eps_pkg::SI_OFFS))
                  + {8'd0, carry_ff};
   assign out_range = idx_w[8]
                  || (idx_w[7:0] >= (base2_ff ? 8'(eps_pkg::BP_COUNT)
                                              : 8'(eps_pkg::SI_COUNT)));
   assign err_final = (err_ff != eps_pkg::ERR_NONE) ? err_ff
                    : (out_range ? eps_pkg::ERR_RANGE : eps_pkg::ERR_NONE);

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      ys_in     = ys_ff;
      base2_in  = base2_ff;
      err_in    = err_ff;
      pw_in     = pw_ff;
      lg_in     = lg_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      dneg_in   = dneg_ff;
      scnt_in   = scnt_ff;
      scaled_in = scaled_ff;
      dv_in     = dv_ff;
      ip_in     = ip_ff;
      n_in      = n_ff;
      ncnt_in   = ncnt_ff;
      fp_in     = fp_ff;
      prod_in   = prod_ff;
      digits_in = digits_ff;
      carry_in  = carry_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {32'd0, scaled_ff};
      div_req.divisor  = dv_ff;
      div_req.qmsb     = eps_pkg::IP_QMSB;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in   = raw[MANTISSA_BITS-1];
               mag_in   = raw[MANTISSA_BITS-1] ? ((~raw + 32'd1) & MMASK) : raw;
               ys_in    = req_data.exponent;
               base2_in = (cfg.number_base == eps_pkg::BASE_BIN);
               pw_in    = (cfg.number_base == eps_pkg::BASE_BIN) ? 36'd2 : 36'd10;
               lg_in    = 6'd0;
               carry_in = 1'b0;
               q_in     = 8'd0;
               if ({28'd0, cfg.precision} > 32'(MAX_PRECISION)) begin
                  err_in   = eps_pkg::ERR_PRECISION;
                  state_in = ST_FINISH;
               end else if (cfg.number_base != eps_pkg::BASE_BIN
                         && cfg.number_base != eps_pkg::BASE_DEC) begin
                  err_in   = eps_pkg::ERR_BASE;
                  state_in = ST_FINISH;
               end else begin
                  err_in   = eps_pkg::ERR_NONE;
                  state_in = ST_LOG;
               end
            end
         end
         ST_LOG: begin
            if ({4'd0, mag_ff} >= pw_ff) begin
               lg_in = lg_ff + 6'd1;
               pw_in = eps_pkg::times_base(pw_ff, base2_ff);
            end else begin
               r_in     = {3'd0, lg_ff} + {ys_ff[7], ys_ff};
               q_in     = 8'd0;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (r_ff[8]) begin
               r_in = r_ff + step;
               q_in = q_ff - 8'd1;
            end else if (r_ff >= step) begin
               r_in = r_ff - step;
               q_in = q_ff + 8'd1;
            end else begin
               dneg_in   = d_w[6];
               scnt_in   = d_w[6] ? 6'(-d_w) : d_w[5:0];
               scaled_in = mag_ff;
               dv_in     = 32'd1;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (scnt_ff != 6'd0) begin
               scnt_in = scnt_ff - 6'd1;
               if (dneg_ff) begin
                  scaled_in = 32'(eps_pkg::times_base({4'd0, scaled_ff}, base2_ff));
               end else begin
                  dv_in = 32'(eps_pkg::times_base({4'd0, dv_ff}, base2_ff));
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_IPDIV;
            end
         end
         ST_IPDIV: begin
            if (div_rsp.done) begin
               ip_in    = div_rsp.quotient[9:0];
               n_in     = {32'd0, div_rsp.remainder};
               ncnt_in  = {1'b0, cfg.precision} + 5'd1;
               state_in = ST_FMUL;
            end
         end
         ST_FMUL: begin
            if (ncnt_ff != 5'd0) begin
               ncnt_in = ncnt_ff - 5'd1;
               n_in    = {n_ff[60:0], 3'b000} + {n_ff[62:0], 1'b0};
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = n_ff;
               div_req.qmsb     = eps_pkg::FP_QMSB;
               state_in         = ST_FPDIV;
            end
         end
         ST_FPDIV: begin
            if (div_rsp.done) begin
               fp_in    = div_rsp.quotient;
               state_in = ST_ROUND_MUL;
            end
         end
         ST_ROUND_MUL: begin
            prod_in  = {32'd0, fp_ff + eps_pkg::ROUND_BIAS} * {32'd0, eps_pkg::DIV10_MUL};
            state_in = ST_ROUND_CHK;
         end
         ST_ROUND_CHK: begin
            digits_in = cfg.precision;
            if (q10 == eps_pkg::pow10(cfg.precision)) begin
               fp_in = 32'd0;
               if (ip_inc == (base2_ff ? eps_pkg::WRAP_BIN : eps_pkg::WRAP_DEC)) begin
                  ip_in    = 10'd1;
                  carry_in = 1'b1;
               end else begin
                  ip_in = ip_inc[9:0];
               end
            end else begin
               fp_in = q10;
            end
            state_in = ST_STRIP_MUL;
         end
         ST_STRIP_MUL: begin
            if (fp_ff == 32'd0) begin
               digits_in = 4'd0;
               state_in  = ST_FINISH;
            end else begin
               prod_in  = {32'd0, fp_ff} * {32'd0, eps_pkg::DIV10_MUL};
               state_in = ST_STRIP_CHK;
            end
         end
         ST_STRIP_CHK: begin
            if (fp_ff == ({q10[28:0], 3'b000} + {q10[30:0], 1'b0})) begin
               fp_in     = q10;
               digits_in = digits_ff - 4'd1;
               state_in  = ST_STRIP_MUL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      res_data.error_code = err_final;
      if (err_final == eps_pkg::ERR_NONE) begin
         res_data.negative     = neg_ff;
         res_data.int_part     = ip_ff;
         res_data.frac_part    = fp_ff[26:0];
         res_data.frac_digits  = digits_ff;
         res_data.prefix_index = idx_w[4:0];
      end else begin
         res_data.negative     = 1'b0;
         res_data.int_part     = 10'd0;
         res_data.frac_part    = 27'd0;
         res_data.frac_digits  = 4'd0;
         res_data.prefix_index = 5'd0;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      ys_ff     <= ys_in;
      base2_ff  <= base2_in;
      err_ff    <= err_in;
      pw_ff     <= pw_in;
      lg_ff     <= lg_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      dneg_ff   <= dneg_in;
      scnt_ff   <= scnt_in;
      scaled_ff <= scaled_in;
      dv_ff     <= dv_in;
      ip_ff     <= ip_in;
      n_ff      <= n_in;
      ncnt_ff   <= ncnt_in;
      fp_ff     <= fp_in;
      prod_ff   <= prod_in;
      digits_ff <= digits_in;
      carry_ff  <= carry_in;
   end

`ifndef SYNTHESIS
   a_fire_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after a transfer");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_IPDIV || state_ff == ST_FPDIV))
      else $error("divider finished outside a divide step");

   a_si_int: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_data.error_code == eps_pkg::ERR_NONE && !base2_ff
      |-> res_data.int_part < 10'd1000)
      else $error("SI integer part not normalized");

   a_frac_digits: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_data.frac_part == 27'd0 |-> res_data.frac_digits == 4'd0)
      else $error("digit count without fraction");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_data.error_code != eps_pkg::ERR_NONE
      |-> res_data.int_part == 10'd0 && res_data.prefix_index == 5'd0)
      else $error("error result carries payload");
`endif

endmodule

// ===== tb/engineering_prefix_scaler_top_tb.sv =====
module engineering_prefix_scaler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   eps_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   eps_pkg::rsp_type  rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   eps_pkg::rsp_type  scaled_q[$];
   logic [3:0]        cur_base;
   logic [3:0]        cur_prec;
   int                error_count;
   bit                quiet;
   bit                hold_rsp;

   engineering_prefix_scaler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint unsigned ipow(longint unsigned b, int n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n; i++) r = r * b;
      return r;
   endfunction

   function automatic int fmod(int a, int m);
      int r;
      r = a % m;
      if (r < 0) r += m;
      return r;
   endfunction

   function automatic eps_pkg::rsp_type scale_to_prefix(eps_pkg::req_type r,
                                                        logic [3:0] base,
                                                        logic [3:0] prec);
      eps_pkg::rsp_type o;
      logic [31:0]      mabs;
      longint unsigned  mag, b, t, scaled, dv, ip, fp;
      int               step, toffs, tcount, lg, ex, d, digits, e, idx, ys, pr;
      logic             neg;
      o = '0;
      pr = prec;
      if (pr > 8) begin
         o.error_code = eps_pkg::ERR_PRECISION;
         return o;
      end
      if (base == eps_pkg::BASE_BIN) begin
         b = 2; step = eps_pkg::BIN_PREFIX_STEP;
         toffs = eps_pkg::BP_OFFS; tcount = eps_pkg::BP_COUNT;
      end else if (base == eps_pkg::BASE_DEC) begin
         b = 10; step = eps_pkg::SI_PREFIX_STEP;
         toffs = eps_pkg::SI_OFFS; tcount = eps_pkg::SI_COUNT;
      end else begin
         o.error_code = eps_pkg::ERR_BASE;
         return o;
      end
      neg = r.mantissa[31];
      mabs = neg ? (~r.mantissa + 32'd1) : r.mantissa;
      mag = mabs;
      ys = r.exponent;
      lg = 0;
      t = mag;
      while (t >= b) begin
         t = t / b;
         lg++;
      end
      ex = lg + ys;
      d = lg - fmod(ex, step);
      scaled = mag;
      if (d < 0) begin
         scaled = scaled * ipow(b, -d);
         d = 0;
      end
      dv = ipow(b, d);
      ip = scaled / dv;
      fp = ipow(10, pr + 1) * (scaled % dv) / dv;
      fp = (fp + 5) / 10;
      digits = pr;
      if (fp == ipow(10, pr)) begin
         ip++;
         fp = 0;
         if (ip == ipow(b, step)) begin
            ip = 1;
            ex += step;
         end
      end
      while (fp != 0 && fp % 10 == 0) begin
         fp = fp / 10;
         digits--;
      end
      if (fp == 0) digits = 0;
      e = (ip == 0 && fp == 0) ? ys : ex;
      idx = (e - fmod(e, step)) / step + toffs;
      if (idx < 0 || idx >= tcount) begin
         o.error_code = eps_pkg::ERR_RANGE;
         return o;
      end
      o.negative     = neg;
      o.int_part     = ip[9:0];
      o.frac_part    = fp[26:0];
      o.frac_digits  = digits[3:0];
      o.prefix_index = idx[4:0];
      o.error_code   = eps_pkg::ERR_NONE;
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 18);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_item(logic signed [31:0] m, logic signed [7:0] x);
      sender_gap();
      @(negedge clock);
      req_valid = 1'b1;
      req_data.mantissa = m;
      req_data.exponent = x;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      scaled_q.push_back(scale_to_prefix(req_data, cur_base, cur_prec));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (scaled_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_access(bit wr, logic [2:0] addr, logic [31:0] wdata);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = wr;
      csr_paddr = addr;
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (!wr && csr_prdata[3:0] != wdata[3:0])
         report("register readback", csr_prdata[3:0], wdata[3:0]);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_config(logic [3:0] base, logic [3:0] prec);
      drain();
      csr_access(1'b1, {eps_pkg::REG_BASE, 2'b00}, {28'd0, base});
      csr_access(1'b1, {eps_pkg::REG_PREC, 2'b00}, {28'd0, prec});
      csr_access(1'b0, {eps_pkg::REG_BASE, 2'b00}, {28'd0, base});
      csr_access(1'b0, {eps_pkg::REG_PREC, 2'b00}, {28'd0, prec});
      cur_base = base;
      cur_prec = prec;
   endtask

   task automatic send_random(int count, bit wide_exp);
      logic signed [31:0] m;
      logic signed [7:0]  x;
      for (int i = 0; i < count; i++) begin
         m = $urandom >> $urandom_range(0, 31);
         if ($urandom_range(0, 1)) m = -m;
         if ($urandom_range(0, 15) == 0) m = $urandom;
         if (wide_exp || $urandom_range(0, 9) == 0)
            x = $urandom;
         else
            x = $urandom_range(0, 60) - 30;
         send_item(m, x);
      end
   endtask

   task automatic test_reset_values();
      csr_access(1'b0, {eps_pkg::REG_BASE, 2'b00}, {28'd0, eps_pkg::BASE_RESET});
      csr_access(1'b0, {eps_pkg::REG_PREC, 2'b00}, {28'd0, eps_pkg::PREC_RESET});
   endtask

   task automatic test_directed();
      send_item(32'sd0, 8'sd0);
      send_item(32'sd0, 8'sh80);
      send_item(32'sd0, 8'sd127);
      send_item(32'sd0, 8'sd24);
      send_item(32'sd1, 8'sd0);
      send_item(-32'sd1, 8'sd0);
      send_item(32'sd2147483647, 8'sd0);
      send_item(32'h8000_0000, 8'sd0);
      send_item(32'sd9995, 8'sd0);
      send_item(32'sd999999, 8'sd0);
      send_item(32'sd1005, -8'sd3);
      send_item(32'sd1, 8'sh80);
      send_item(32'sd1, 8'sd127);
      send_item(32'sd123456, 8'sd20);
      set_config(eps_pkg::BASE_BIN, 4'd8);
      send_item(32'sd1023, 8'sd0);
      send_item(32'sd1048575, 8'sd0);
      send_item(-32'sd1, 8'sd89);
      send_item(32'sd3, -8'sd1);
      send_item(32'h8000_0000, 8'sd49);
      send_item(32'sd0, 8'sd95);
   endtask

   task automatic test_errors();
      set_config(eps_pkg::BASE_DEC, 4'd9);
      send_random(4, 1'b1);
      set_config(eps_pkg::BASE_DEC, 4'd15);
      send_random(4, 1'b1);
      set_config(4'd0, 4'd2);
      send_random(4, 1'b1);
      set_config(4'd15, 4'd0);
      send_random(4, 1'b1);
      set_config(4'd3, 4'd15);
      send_random(4, 1'b1);
   endtask

   task automatic test_random_settings();
      set_config(eps_pkg::BASE_DEC, 4'd0);
      send_random(140, 1'b0);
      set_config(eps_pkg::BASE_DEC, 4'd8);
      send_random(140, 1'b0);
      set_config(eps_pkg::BASE_BIN, 4'd0);
      send_random(140, 1'b0);
      set_config(eps_pkg::BASE_BIN, 4'd8);
      send_random(140, 1'b0);
      set_config(eps_pkg::BASE_DEC, 4'($urandom_range(1, 7)));
      send_random(120, 1'b0);
      set_config(eps_pkg::BASE_BIN, 4'($urandom_range(1, 7)));
      send_random(120, 1'b1);
   endtask

   task automatic test_backpressure();
      set_config(eps_pkg::BASE_DEC, 4'd3);
      hold_rsp = 1'b1;
      send_random(25, 1'b0);
   endtask

   task automatic test_full_rate();
      set_config(eps_pkg::BASE_DEC, 4'd4);
      quiet = 1'b1;
      send_random(100, 1'b0);
   endtask

   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            for (int i = 0; i < 600; i++) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      eps_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scaled_q.size() == 0) begin
            report("unexpected result transfer", 1, 0);
         end else begin
            want = scaled_q.pop_front();
            if (rsp_data.negative != want.negative)
               report("negative", rsp_data.negative, want.negative);
            if (rsp_data.int_part != want.int_part)
               report("int_part", rsp_data.int_part, want.int_part);
            if (rsp_data.frac_part != want.frac_part)
               report("frac_part", rsp_data.frac_part, want.frac_part);
            if (rsp_data.frac_digits != want.frac_digits)
               report("frac_digits", rsp_data.frac_digits, want.frac_digits);
            if (rsp_data.prefix_index != want.prefix_index)
               report("prefix_index", rsp_data.prefix_index, want.prefix_index);
            if (rsp_data.error_code != want.error_code)
               report("error_code", rsp_data.error_code, want.error_code);
         end
      end
   end

   initial begin
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      error_count = 0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cur_base = eps_pkg::BASE_RESET;
      cur_prec = eps_pkg::PREC_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_directed();
      test_errors();
      test_random_settings();
      test_backpressure();
      test_full_rate();
      drain();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
